[sv/assert_macros.svh]
// Assertion helpers for the hash table checker.
// Each macro samples on the rising edge of clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define PKH_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hash table check failed");

`define PKH_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hash table check failed");

`endif

[sv/pkh_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pointer key hash table package
// Sizes, codes and word types shared by the table, its hash unit and checker.
// ----------------------------------------------------------------------------
package pkh_pkg;

	localparam int SLOTS   = 1024;
	localparam int SLOT_W  = $clog2(SLOTS);
	localparam int KEY_W   = 64;
	localparam int HASH_W  = 31;
	localparam int CNT_W   = 11;
	localparam int SLOT_FW = 10;
	localparam int STAT_W  = 2;

	localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
	localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;
	localparam logic [STAT_W-1:0] ST_ZERO_KEY  = 2'd3;

	localparam logic CMD_FIND   = 1'b0;
	localparam logic CMD_OBTAIN = 1'b1;

	localparam logic [CNT_W-1:0] FILL_RESET = 11'd716;

	typedef struct packed {
		logic             cmd;
		logic [KEY_W-1:0] key;
	} pkh_req_t;

	typedef struct packed {
		logic [STAT_W-1:0]  status;
		logic [SLOT_FW-1:0] slot;
		logic               existed;
		logic [HASH_W-1:0]  key_hash;
	} pkh_rsp_t;

	typedef struct packed {
		logic              present;
		logic [HASH_W-1:0] hash;
		logic [KEY_W-1:0]  key;
	} pkh_entry_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_HASH,
		S_RD,
		S_CHK
	} pkh_state_t;

endpackage

[sv/pointer_key_hash_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pointer key hash table
// Open-addressed table of 64-bit pointer keys with linear probing.
// ----------------------------------------------------------------------------
// A command word (req: cmd, key) is taken at a rising edge where start is high
// and busy is low. A find looks the key up; an obtain returns the key's slot or
// claims the first free slot on its probe path, unless the stored count has
// reached fill_limit, in which case it reports full. A zero key is rejected.
// Each command gives exactly one response word on rsp, shown for one cycle
// with done high; the receiver cannot stall and must take it then.
// The 64-bit hash mix runs seven steps through one shared adder/xor unit, and
// each slot probed costs one read of the single-port slot memory (state S_RD)
// followed by a key compare (S_CHK). A zero key answers after the hash alone.
// busy drops in the cycle where done is high, so the next word can already be
// taken while the response is shown. One command is in flight at a time.
// fill_limit is written at any edge where fill_limit_we is high.
// After reset the block sweeps the slot memory to clear it, with busy high,
// before it takes its first command.
// ----------------------------------------------------------------------------
module pointer_key_hash_table (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  pkh_pkg::pkh_req_t         req,
	output logic                      done,
	output pkh_pkg::pkh_rsp_t         rsp,
	input  logic                      fill_limit_we,
	input  logic [pkh_pkg::CNT_W-1:0] fill_limit
);
	import pkh_pkg::*;

	pkh_entry_t mem [SLOTS];
	pkh_entry_t rd_q;

	pkh_state_t        state_q;
	pkh_state_t        state_nxt;
	pkh_req_t          req_q;
	pkh_rsp_t          rsp_q;
	logic              done_q;
	logic [CNT_W-1:0]  fill_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [SLOT_W-1:0] idx_q;
	logic [SLOT_W-1:0] probes_q;
	logic [SLOT_W-1:0] clr_q;

	logic              hash_start;
	logic              hash_done;
	logic [HASH_W-1:0] hash;

	logic              key_zero;
	logic              hit;
	logic              slot_free;
	logic              room;
	logic              probe_last;

	logic              mem_we;
	logic [SLOT_W-1:0] mem_addr;
	pkh_entry_t        mem_wdata;
	logic              emit;
	logic [STAT_W-1:0] emit_status;
	logic              emit_existed;
	logic              probe_next;

	pkh_hash u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (hash_start),
		.key    (req.key),
		.done   (hash_done),
		.hash   (hash)
	);

	assign key_zero   = (req_q.key == '0);
	assign hit        = rd_q.present && (rd_q.hash == hash) && (rd_q.key == req_q.key);
	assign slot_free  = !rd_q.present;
	assign room       = (cnt_q < fill_q) && (cnt_q != '1) && (32'(cnt_q) < SLOTS);
	assign probe_last = &probes_q;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_CLEAR: begin
				if (&clr_q) begin
					state_nxt = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					state_nxt = S_HASH;
				end
			end
			S_HASH: begin
				if (hash_done) begin
					state_nxt = key_zero ? S_IDLE : S_RD;
				end
			end
			S_RD: begin
				state_nxt = S_CHK;
			end
			S_CHK: begin
				state_nxt = emit ? S_IDLE : S_RD;
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_comb begin
		hash_start   = 1'b0;
		mem_we       = 1'b0;
		mem_addr     = idx_q;
		mem_wdata    = '0;
		emit         = 1'b0;
		emit_status  = ST_NOT_FOUND;
		emit_existed = 1'b0;
		probe_next   = 1'b0;
		case (state_q)
			S_CLEAR: begin
				mem_we   = 1'b1;
				mem_addr = clr_q;
			end
			S_IDLE: begin
				hash_start = start;
			end
			S_HASH: begin
				if (hash_done && key_zero) begin
					emit        = 1'b1;
					emit_status = ST_ZERO_KEY;
				end
			end
			S_RD: begin
				mem_addr = idx_q;
			end
			S_CHK: begin
				if (hit) begin
					emit         = 1'b1;
					emit_status  = ST_OK;
					emit_existed = 1'b1;
				end else if (slot_free) begin
					emit = 1'b1;
					if (req_q.cmd == CMD_OBTAIN && room) begin
						mem_we            = 1'b1;
						mem_wdata.present = 1'b1;
						mem_wdata.hash    = hash;
						mem_wdata.key     = req_q.key;
						emit_status       = ST_OK;
					end else begin
						emit_status = (req_q.cmd == CMD_OBTAIN) ? ST_FULL : ST_NOT_FOUND;
					end
				end else if (probe_last) begin
					emit        = 1'b1;
					emit_status = (req_q.cmd == CMD_OBTAIN) ? ST_FULL : ST_NOT_FOUND;
				end else begin
					probe_next = 1'b1;
				end
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end
		rd_q <= mem[mem_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			done_q  <= 1'b0;
			fill_q  <= FILL_RESET;
			cnt_q   <= '0;
			clr_q   <= '0;
		end else begin
			state_q <= state_nxt;
			done_q  <= emit;
			if (fill_limit_we) begin
				fill_q <= fill_limit;
			end
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + SLOT_W'(1);
			end else if (mem_we) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			req_q <= req;
		end
		if (state_q == S_HASH && hash_done) begin
			idx_q    <= hash[SLOT_W-1:0];
			probes_q <= '0;
		end else if (probe_next) begin
			idx_q    <= idx_q + SLOT_W'(1);
			probes_q <= probes_q + SLOT_W'(1);
		end
		if (emit) begin
			rsp_q.status   <= emit_status;
			rsp_q.slot     <= (emit_status == ST_OK) ? SLOT_FW'(idx_q) : '0;
			rsp_q.existed  <= emit_existed;
			rsp_q.key_hash <= hash;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

[sv/pkh_hash.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pointer key hash unit
// Computes the 31-bit shift/xor/multiply mix of a 64-bit key with one shared
// adder/xor unit, one step per cycle over seven steps.
// ----------------------------------------------------------------------------
module pkh_hash (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [pkh_pkg::KEY_W-1:0] key,
	output logic                      done,
	output logic [pkh_pkg::HASH_W-1:0] hash
);
	import pkh_pkg::*;

	localparam logic [2:0] STEP_INV  = 3'd0;
	localparam logic [2:0] STEP_X31  = 3'd1;
	localparam logic [2:0] STEP_MUL5 = 3'd2;
	localparam logic [2:0] STEP_MUL  = 3'd3;
	localparam logic [2:0] STEP_X11  = 3'd4;
	localparam logic [2:0] STEP_ADD6 = 3'd5;
	localparam logic [2:0] STEP_X22  = 3'd6;

	logic [KEY_W-1:0] h_q;
	logic [KEY_W-1:0] g_q;
	logic [2:0]       step_q;
	logic             run_q;
	logic             done_q;
	logic [KEY_W-1:0] op_a;
	logic [KEY_W-1:0] op_b;
	logic             op_add;
	logic [KEY_W-1:0] res;

	always_comb begin
		op_a   = h_q;
		op_b   = '0;
		op_add = 1'b0;
		case (step_q)
			STEP_INV: begin
				op_a   = ~h_q;
				op_b   = h_q << 18;
				op_add = 1'b1;
			end
			STEP_X31: begin
				op_b = h_q >> 31;
			end
			STEP_MUL5: begin
				op_b   = h_q << 2;
				op_add = 1'b1;
			end
			STEP_MUL: begin
				op_b   = g_q << 2;
				op_add = 1'b1;
			end
			STEP_X11: begin
				op_b = h_q >> 11;
			end
			STEP_ADD6: begin
				op_b   = h_q << 6;
				op_add = 1'b1;
			end
			STEP_X22: begin
				op_b = h_q >> 22;
			end
			default: begin
				op_b = '0;
			end
		endcase
		res = op_add ? (op_a + op_b) : (op_a ^ op_b);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			step_q <= STEP_INV;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q  <= 1'b1;
				step_q <= STEP_INV;
			end else if (run_q) begin
				step_q <= step_q + 3'd1;
				if (step_q == STEP_X22) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			h_q <= key;
		end else if (run_q) begin
			if (step_q == STEP_MUL5) begin
				g_q <= res;
			end else begin
				h_q <= res;
			end
		end
	end

	assign done = done_q;
	assign hash = h_q[HASH_W-1:0];

endmodule

[sv/pkh_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pointer key hash table checker
// Port-level assertions on the command and response words of the table.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pkh_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      start,
	input logic                      busy,
	input pkh_pkg::pkh_req_t         req,
	input logic                      done,
	input pkh_pkg::pkh_rsp_t         rsp,
	input logic                      fill_limit_we,
	input logic [pkh_pkg::CNT_W-1:0] fill_limit
);
	import pkh_pkg::*;

	logic unused_inputs;

	assign unused_inputs = ^{req, fill_limit_we, fill_limit};

	// A taken command raises busy and is not answered in the cycle after it is taken.
	`PKH_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !done)

	// Only one response word per command, so strobes never come back to back.
	`PKH_ASSERT_NEXT(a_done_single, done, !done)

	// A failed command reports neither a slot nor a previous entry.
	`PKH_ASSERT_SAME(a_fail_clean, done && rsp.status != ST_OK,
		rsp.slot == '0 && !rsp.existed)

	// A key that was already stored is always a success.
	`PKH_ASSERT_SAME(a_existed_ok, done && rsp.existed, rsp.status == ST_OK)

endmodule

bind pointer_key_hash_table pkh_checker u_pkh_checker (.*);
